// ----- hdl/ile_pkg.sv -----
// Shared constants for the indexed list engine: field widths, command and
// status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

   localparam int WORD_W  = 32;
   localparam int IDX_W   = 8;
   localparam int CMD_W   = 3;
   localparam int ST_W    = 2;
   localparam int CNT_O_W = 9;

   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_OOB      = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

endpackage : ile_pkg

`default_nettype wire

// ----- hdl/indexed_list_engine_top.sv -----
// Indexed list engine top level: command sequencer and used-entry count
// around the entry store. Depends on ile_pkg and ile_ram.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries req_command (append, read, write, search, remove), req_index
//   and req_value. Exactly one result follows, shown for one cycle with
//   rsp_valid high: rsp_status, rsp_data, rsp_count and rsp_empty_res.
//   How each command reaches rsp_valid after the accepting edge:
//     append, write, error cases, unknown commands: answered directly
//     read: one store read
//     search: entries compared in turn from index 0 until a match, up to count
//     remove at index i: the entries above i move down, one entry moved down
//       per cycle through the store's single read and write port
//   busy is high while a read, search or remove is in progress; a new
//   request may be taken in the cycle its predecessor's result is shown.
//   Reset (synchronous, active high) empties the list; the store itself is
//   not cleared. The receiver cannot stall: each result is taken as shown.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine_top
   import ile_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [IDX_W-1:0]    req_index,
   input  wire logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [ST_W-1:0]          rsp_status,
   output logic signed [WORD_W-1:0] rsp_data,
   output logic [CNT_O_W-1:0]       rsp_count,
   output logic                     rsp_empty_res
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_SRCH = 4'b0100,
      S_RMV  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [WORD_W-1:0] val_ff, val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_O_W-1:0] rsp_count_ff;
   logic              rsp_empty_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_rdata;

   logic              idx_ok;
   logic [AW-1:0]     idx_a;
   logic              ptr_last;

   ile_ram #(
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign idx_ok   = XW'(req_index) < XW'(count_ff);
   assign idx_a    = AW'(req_index);
   assign ptr_last = (CW'(ptr_ff) + CW'(1)) >= count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      val_in        = val_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = mem_rdata;
      mem_raddr     = ptr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in = req_value;
               unique case (req_command)
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CW'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(count_ff);
                        mem_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  CMD_READ: begin
                     if (idx_ok) begin
                        mem_raddr = idx_a;
                        state_in  = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OOB;
                     end
                  end
                  CMD_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (idx_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_a;
                        mem_wdata = req_value;
                     end else begin
                        rsp_status_in = ST_OOB;
                     end
                  end
                  CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        mem_raddr = '0;
                        ptr_in    = '0;
                        state_in  = S_SRCH;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!idx_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OOB;
                     end else if ((XW'(req_index) + XW'(1)) >= XW'(count_ff)) begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff - CW'(1);
                     end else begin
                        mem_raddr = idx_a + AW'(1);
                        ptr_in    = idx_a + AW'(1);
                        state_in  = S_RMV;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = mem_rdata;
            state_in     = S_IDLE;
         end
         S_SRCH: begin
            if (mem_rdata == val_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = WORD_W'(ptr_ff);
               state_in     = S_IDLE;
            end else if (ptr_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOTFOUND;
               state_in      = S_IDLE;
            end else begin
               mem_raddr = ptr_ff + AW'(1);
               ptr_in    = ptr_ff + AW'(1);
            end
         end
         S_RMV: begin
            // entry at ptr moves down one place
            mem_we    = 1'b1;
            mem_waddr = ptr_ff - AW'(1);
            mem_wdata = mem_rdata;
            if (ptr_last) begin
               rsp_valid_in = 1'b1;
               count_in     = count_ff - CW'(1);
               state_in     = S_IDLE;
            end else begin
               mem_raddr = ptr_ff + AW'(1);
               ptr_in    = ptr_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      val_ff <= val_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= CNT_O_W'(count_in);
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

`ifndef ASSERT_OFF
   a_accept_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("request neither answered nor in progress");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH || state_ff == S_RMV) |-> (count_ff != '0))
      else $error("walking an empty list");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) <= count_ff))
      else $error("store write beyond used entries");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count above capacity");
`endif

endmodule : indexed_list_engine_top

`default_nettype wire

// ----- hdl/ile_ram.sv -----
// Entry store of the indexed list engine: one write port, one read port,
// registered read data. Depends on ile_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ile_ram
   import ile_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WORD_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WORD_W-1:0]        rd_data
);

   logic [WORD_W-1:0] store_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : ile_ram

`default_nettype wire
